// ===== hw/rtl/pba_pkg.sv =====
// Package with the constants, types and codes shared by the port bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
package pba_pkg;

   localparam int PORT_COUNT  = 65536;
   localparam int FIRST_PORT  = 49152;
   localparam int GROUP_COUNT = 8192;

   localparam int PORT_W     = 16;
   localparam int GROUP_BITS = 8;
   localparam int BIT_SEL_W  = $clog2(GROUP_BITS);
   localparam int GRP_IDX_W  = PORT_W - BIT_SEL_W;
   localparam int GRP_ADDR_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

   typedef logic [1:0]            kind_type;
   typedef logic [1:0]            status_type;
   typedef logic [PORT_W-1:0]     port_type;
   typedef logic [PORT_W:0]       port_ext_type;
   typedef logic [GROUP_BITS-1:0] group_type;
   typedef logic [BIT_SEL_W-1:0]  bit_sel_type;
   typedef logic [GRP_IDX_W-1:0]  grp_idx_type;
   typedef logic [GRP_IDX_W:0]    grp_ext_type;
   typedef logic [GRP_ADDR_W-1:0] grp_addr_type;

   localparam port_ext_type PORT_LIMIT   = port_ext_type'(PORT_COUNT);
   localparam grp_ext_type  GROUP_LIMIT  = grp_ext_type'(GROUP_COUNT);
   localparam grp_addr_type LAST_GROUP   = grp_addr_type'(GROUP_COUNT - 1);
   localparam port_type     START_CURSOR = port_type'(FIRST_PORT & ~(GROUP_BITS - 1));
   localparam port_ext_type GROUP_STEP   = port_ext_type'(GROUP_BITS);
   localparam group_type    GROUP_FULL   = group_type'(8'hff);

   localparam kind_type KIND_ALLOC   = 2'd0;
   localparam kind_type KIND_CLAIM   = 2'd1;
   localparam kind_type KIND_RELEASE = 2'd2;

   localparam status_type ST_DONE    = 2'd0;
   localparam status_type ST_NO_FREE = 2'd1;
   localparam status_type ST_TAKEN   = 2'd2;
   localparam status_type ST_IGNORED = 2'd3;

   typedef struct packed {
      logic        full;
      bit_sel_type free_idx;
      logic        held;
      group_type   alloc_bits;
      group_type   mark_bits;
      group_type   clear_bits;
   } group_info_type;

endpackage
`default_nettype wire

// ===== hw/rtl/pba_req_if.sv =====
// Request channel interface of the port bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
interface pba_req_if;
   logic              valid;
   logic              ready;
   pba_pkg::kind_type kind;
   pba_pkg::port_type port_number;

   modport source (output valid, output kind, output port_number, input ready);
   modport sink (input valid, input kind, input port_number, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pba_rsp_if.sv =====
// Response channel interface of the port bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
interface pba_rsp_if;
   logic                valid;
   logic                ready;
   pba_pkg::port_type   granted_port;
   pba_pkg::status_type status;

   modport source (output valid, output granted_port, output status, input ready);
   modport sink (input valid, input granted_port, input status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/port_bitmap_allocator.sv =====
// Top level of the port bitmap allocator: bitmap memory, search cursor and request sequencer.
// After reset the block sweeps the bitmap memory clear, one group per cycle, over all
// GROUP_COUNT (8192) groups, and takes no request meanwhile. A claim or release then
// goes from acceptance through one memory read, one decision and one output load, which
// waits while a response is still held. An allocate reads one 8-port group at a time
// through the single bitmap read port, a read and a decision per group; a pool that is
// full costs two passes from the cursor over the groups above the first port, at most
// 4096 group reads. Kind 3 goes straight to the output load. One request is in work at
// a time; the response register lets the next request be accepted while a response waits.
`timescale 1ns / 1ps
`default_nettype none
module port_bitmap_allocator (
   input  var logic clock,
   input  var logic reset,
   pba_req_if.sink   req_if,
   pba_rsp_if.source rsp_if
);
   import pba_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   group_type mem [GROUP_COUNT];

   logic [2:0]   state_ff, state_in;
   grp_addr_type clear_cnt_ff, clear_cnt_in;
   port_type     cursor_ff, cursor_in;
   logic         wrap_ff, wrap_in;
   kind_type     kind_ff, kind_in;
   port_type     port_ff, port_in;
   logic         range_ff, range_in;
   port_type     res_granted_ff, res_granted_in;
   status_type   res_status_ff, res_status_in;
   logic         rsp_valid_ff, rsp_valid_in;
   port_type     rsp_granted_ff, rsp_granted_in;
   status_type   rsp_status_ff, rsp_status_in;
   group_type    rd_data_ff;

   logic         mem_we;
   grp_addr_type mem_waddr;
   group_type    mem_wdata;
   grp_addr_type mem_raddr;

   grp_idx_type    cur_grp;
   grp_idx_type    port_grp;
   logic           cur_in_store;
   port_ext_type   cursor_next;
   group_info_type info;

   assign cur_grp      = cursor_ff[PORT_W-1:BIT_SEL_W];
   assign port_grp     = port_ff[PORT_W-1:BIT_SEL_W];
   assign cur_in_store = {1'b0, cur_grp} < GROUP_LIMIT;
   assign cursor_next  = {1'b0, cursor_ff} + GROUP_STEP;

   pba_group_unit u_group (
      .group_bits (rd_data_ff),
      .bit_sel    (port_ff[BIT_SEL_W-1:0]),
      .in_store   ((kind_ff == KIND_ALLOC) ? cur_in_store : 1'b1),
      .info       (info)
   );

   assign mem_raddr = (kind_ff == KIND_ALLOC) ? cur_grp[GRP_ADDR_W-1:0]
                                              : port_grp[GRP_ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_comb begin
      state_in       = state_ff;
      clear_cnt_in   = clear_cnt_ff;
      cursor_in      = cursor_ff;
      wrap_in        = wrap_ff;
      kind_in        = kind_ff;
      port_in        = port_ff;
      range_in       = range_ff;
      res_granted_in = res_granted_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      mem_we         = 1'b0;
      mem_waddr      = cur_grp[GRP_ADDR_W-1:0];
      mem_wdata      = info.alloc_bits;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we       = 1'b1;
            mem_waddr    = clear_cnt_ff;
            mem_wdata    = '0;
            clear_cnt_in = clear_cnt_ff + grp_addr_type'(1);
            if (clear_cnt_ff == LAST_GROUP) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_if.valid) begin
               kind_in  = req_if.kind;
               port_in  = req_if.port_number;
               range_in = ({1'b0, req_if.port_number} < PORT_LIMIT)
                  && ({1'b0, req_if.port_number[PORT_W-1:BIT_SEL_W]} < GROUP_LIMIT);
               wrap_in  = 1'b0;
               if (req_if.kind == KIND_ALLOC || req_if.kind == KIND_CLAIM
                   || req_if.kind == KIND_RELEASE) begin
                  state_in = S_READ;
               end else begin
                  res_granted_in = '0;
                  res_status_in  = ST_IGNORED;
                  state_in       = S_OUT;
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            res_granted_in = '0;
            state_in       = S_OUT;
            priority case (kind_ff)
               KIND_ALLOC: begin
                  if (!info.full) begin
                     mem_we         = 1'b1;
                     mem_waddr      = cur_grp[GRP_ADDR_W-1:0];
                     mem_wdata      = info.alloc_bits;
                     res_granted_in = {cur_grp, info.free_idx};
                     res_status_in  = ST_DONE;
                  end else if (cursor_next >= PORT_LIMIT) begin
                     cursor_in = START_CURSOR;
                     wrap_in   = 1'b1;
                     if (wrap_ff) begin
                        res_status_in = ST_NO_FREE;
                     end else begin
                        state_in = S_READ;
                     end
                  end else begin
                     cursor_in = cursor_next[PORT_W-1:0];
                     state_in  = S_READ;
                  end
               end
               KIND_CLAIM: begin
                  if (!range_ff || info.held) begin
                     res_status_in = ST_TAKEN;
                  end else begin
                     mem_we         = 1'b1;
                     mem_waddr      = port_grp[GRP_ADDR_W-1:0];
                     mem_wdata      = info.mark_bits;
                     res_granted_in = port_ff;
                     res_status_in  = ST_DONE;
                  end
               end
               KIND_RELEASE: begin
                  if (!range_ff || !info.held) begin
                     res_status_in = ST_IGNORED;
                  end else begin
                     mem_we        = 1'b1;
                     mem_waddr     = port_grp[GRP_ADDR_W-1:0];
                     mem_wdata     = info.clear_bits;
                     res_status_in = ST_DONE;
                  end
               end
               default: begin
                  res_status_in = ST_IGNORED;
               end
            endcase
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_status_in  = res_status_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_cnt_ff <= '0;
         cursor_ff    <= START_CURSOR;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         cursor_ff    <= cursor_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      port_ff        <= port_in;
      range_ff       <= range_in;
      res_granted_ff <= res_granted_in;
      res_status_ff  <= res_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign req_if.ready        = (state_ff == S_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.granted_port = rsp_granted_ff;
   assign rsp_if.status       = rsp_status_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/pba_group_unit.sv =====
// Shared group inspection unit: lowest free bit, held bit test and updated group values.
`timescale 1ns / 1ps
`default_nettype none
module pba_group_unit (
   input  var pba_pkg::group_type      group_bits,
   input  var pba_pkg::bit_sel_type    bit_sel,
   input  var logic                    in_store,
   output var pba_pkg::group_info_type info
);
   import pba_pkg::*;

   group_type   sel_mask;
   group_type   free_mask;
   bit_sel_type free_idx;

   always_comb begin
      free_idx = '0;
      for (int i = GROUP_BITS - 1; i >= 0; i--) begin
         if (!group_bits[i]) begin
            free_idx = bit_sel_type'(i);
         end
      end
   end

   assign sel_mask  = group_type'(1) << bit_sel;
   assign free_mask = group_type'(1) << free_idx;

   always_comb begin
      info.full       = !in_store || (group_bits == GROUP_FULL);
      info.free_idx   = free_idx;
      info.held       = (group_bits & sel_mask) != '0;
      info.alloc_bits = group_bits | free_mask;
      info.mark_bits  = group_bits | sel_mask;
      info.clear_bits = group_bits & ~sel_mask;
   end

endmodule
`default_nettype wire
